/* hdl/gatd_pkg.sv */
package gatd_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_WIDTH_A       = 3'd0;
	localparam logic [2:0] REG_HEIGHT_A      = 3'd1;
	localparam logic [2:0] REG_WIDTH_B       = 3'd2;
	localparam logic [2:0] REG_HEIGHT_B      = 3'd3;
	localparam logic [2:0] REG_SEARCH_WINDOW = 3'd4;

	localparam logic [6:0] DIM_RESET = 7'd64;
	localparam logic [3:0] WIN_RESET = 4'd2;

	localparam logic [7:0] MISS_COST = 8'd128;

	// input action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// one stored pixel
	typedef struct packed {
		logic [7:0] angle;
		logic       mask;
		logic       eroded;
	} pix_t;

	// wrapped byte angle distance, 0..128
	function automatic logic [7:0] angle_dist(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = a - b;
		return (d > 8'd128) ? 8'(-d) : d;
	endfunction

endpackage

/* hdl/gradient_angle_template_distance.sv */
// Gradient orientation template distance between two stored images A and B.
// Input channel (in_valid/in_ready): action 0 writes one pixel (angle, mask,
// eroded bit) of the image chosen by which_image; loads outside
// MAX_WIDTH x MAX_HEIGHT are dropped. Action 1 starts a compute that
// returns one result on the output channel (out_valid/out_ready).
// Configuration channel (cfg_valid/cfg_ready, always ready) sets sizes and
// search window; write it only while no compute is running.
// A compute runs a centroid scan over the whole MAX_WIDTH x MAX_HEIGHT area,
// four centroid divides, an offset search over (2*win+1)^2 offsets in each
// direction and two ratio divides. The offset search reads one source and
// one target pixel per cycle from the two pixel memories. One compute runs
// at a time; in_ready is low until the result is written to the output
// register. If the receiver stalls, the result holds and a new compute is
// taken but waits at its end until the output register is free.
// Reset returns sizes to 64 and the window to 2; pixel memories are not
// cleared and must be loaded before a compute reads them.
module gradient_angle_template_distance #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_WINDOW = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        which_image,
	input  logic [5:0]  pix_x,
	input  logic [5:0]  pix_y,
	input  logic [7:0]  pix_angle,
	input  logic        pix_in_mask,
	input  logic        pix_in_eroded,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] distance_q8,
	output logic [19:0] diff_a_to_b,
	output logic [19:0] diff_b_to_a,
	output logic [12:0] count_a,
	output logic [12:0] count_b,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import gatd_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int DWX    = $clog2(MAX_WIDTH + 1);
	localparam int DWY    = $clog2(MAX_HEIGHT + 1);
	localparam int WW     = $clog2(MAX_WINDOW + 1);
	localparam int MW0    = (XW > YW) ? XW : YW;
	localparam int MW     = (MW0 > WW) ? MW0 : WW;
	localparam int CW     = MW + 3;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SX_W   = CNT_W + XW;
	localparam int SY_W   = CNT_W + YW;
	localparam int DIFF_W = CNT_W + 8;
	localparam int NUM_W  = DIFF_W + 8;
	localparam int DCW    = $clog2(NUM_W + 2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CSCAN = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MATCH = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [2:0] JOB_CX_A = 3'd0;
	localparam logic [2:0] JOB_CY_A = 3'd1;
	localparam logic [2:0] JOB_CX_B = 3'd2;
	localparam logic [2:0] JOB_CY_B = 3'd3;
	localparam logic [2:0] JOB_Q_A  = 3'd4;
	localparam logic [2:0] JOB_Q_B  = 3'd5;

	logic [2:0] st_q;
	logic [6:0] cfg_wa_q, cfg_ha_q, cfg_wb_q, cfg_hb_q;
	logic [3:0] cfg_win_q;

	logic [DWX-1:0] wa, wb, ws, wt;
	logic [DWY-1:0] ha, hb, hs, ht;
	logic signed [CW-1:0] win;

	// pixel memories
	pix_t mem_a [DEPTH];
	pix_t mem_b [DEPTH];
	pix_t rd_a, rd_b, wr_pix;
	logic [AW-1:0] raddr_a, raddr_b, waddr;
	logic we_a, we_b;

	// scan and offset counters
	logic issue_q, dir_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic signed [CW-1:0] ox_q, oy_q, ox_lo_q, ox_hi_q, oy_hi_q;
	logic signed [CW-1:0] tx, ty, dxs, dys;
	logic [XW-1:0] x_end;
	logic [YW-1:0] y_end;
	logic x_last, y_last, last_pix, last_all, inr;
	logic [AW-1:0] src_addr, tgt_addr;

	// first pipeline stage, aligned with memory read data
	logic v_s1, last_s1, end_s1, dir_s1, inr_s1, in_a_s1, in_b_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;

	// accumulators
	logic [CNT_W-1:0] na_q, nb_q, na_den, nb_den;
	logic [SX_W-1:0] sxa_q, sxb_q;
	logic [SY_W-1:0] sya_q, syb_q;
	logic [XW-1:0] cxa_q, cxb_q;
	logic [YW-1:0] cya_q, cyb_q;
	logic [DIFF_W-1:0] sum_q, best_q, sum_now, best_new, da_q, db_q;
	logic [15:0] qa_q, qb_q;
	pix_t src_px, tgt_px;
	logic [7:0] cost;

	// shared divider
	logic [2:0] job_q;
	logic [DCW-1:0] dcnt_q;
	logic [NUM_W-1:0] quo_q, num_sel;
	logic [CNT_W-1:0] rem_q, den;
	logic [CNT_W:0] trial;
	logic ge;

	logic out_valid_q;
	logic [15:0] dist_q;
	logic [19:0] oda_q, odb_q;
	logic [12:0] ona_q, onb_q;

	// clamp configured sizes and window
	assign wa = (cfg_wa_q == '0) ? DWX'(1) :
		((32'(cfg_wa_q) > MAX_WIDTH) ? DWX'(MAX_WIDTH) : DWX'(cfg_wa_q));
	assign wb = (cfg_wb_q == '0) ? DWX'(1) :
		((32'(cfg_wb_q) > MAX_WIDTH) ? DWX'(MAX_WIDTH) : DWX'(cfg_wb_q));
	assign ha = (cfg_ha_q == '0) ? DWY'(1) :
		((32'(cfg_ha_q) > MAX_HEIGHT) ? DWY'(MAX_HEIGHT) : DWY'(cfg_ha_q));
	assign hb = (cfg_hb_q == '0) ? DWY'(1) :
		((32'(cfg_hb_q) > MAX_HEIGHT) ? DWY'(MAX_HEIGHT) : DWY'(cfg_hb_q));
	assign win = (32'(cfg_win_q) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(cfg_win_q);

	assign ws = dir_q ? wb : wa;
	assign hs = dir_q ? hb : ha;
	assign wt = dir_q ? wa : wb;
	assign ht = dir_q ? ha : hb;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wa_q  <= DIM_RESET;
			cfg_ha_q  <= DIM_RESET;
			cfg_wb_q  <= DIM_RESET;
			cfg_hb_q  <= DIM_RESET;
			cfg_win_q <= WIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH_A:       cfg_wa_q  <= cfg_data;
				REG_HEIGHT_A:      cfg_ha_q  <= cfg_data;
				REG_WIDTH_B:       cfg_wb_q  <= cfg_data;
				REG_HEIGHT_B:      cfg_hb_q  <= cfg_data;
				REG_SEARCH_WINDOW: cfg_win_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// pixel load
	assign wr_pix = '{angle: pix_angle, mask: pix_in_mask, eroded: pix_in_eroded};
	assign waddr = AW'(pix_y) * AW'(MAX_WIDTH) + AW'(pix_x);
	always_comb begin
		we_a = 1'b0;
		we_b = 1'b0;
		if (in_valid && in_ready && action == ACT_LOAD &&
				32'(pix_x) < MAX_WIDTH && 32'(pix_y) < MAX_HEIGHT) begin
			we_a = !which_image;
			we_b = which_image;
		end
	end

	// scan position and target position
	assign x_end = (st_q == ST_CSCAN) ? XW'(MAX_WIDTH - 1) : XW'(ws - DWX'(1));
	assign y_end = (st_q == ST_CSCAN) ? YW'(MAX_HEIGHT - 1) : YW'(hs - DWY'(1));
	assign x_last = (x_q == x_end);
	assign y_last = (y_q == y_end);
	assign last_pix = x_last && y_last;
	assign last_all = last_pix && (ox_q == ox_hi_q) && (oy_q == oy_hi_q);
	assign tx = $signed(CW'(x_q)) - ox_q;
	assign ty = $signed(CW'(y_q)) - oy_q;
	assign inr = (tx >= 0) && (tx < $signed(CW'(wt))) && (ty >= 0) && (ty < $signed(CW'(ht)));
	assign src_addr = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);
	assign tgt_addr = AW'(ty[YW-1:0]) * AW'(MAX_WIDTH) + AW'(tx[XW-1:0]);

	// read addresses: source and target swap with direction
	always_comb begin
		if (st_q == ST_CSCAN || !dir_q) begin
			raddr_a = src_addr;
			raddr_b = (st_q == ST_CSCAN) ? src_addr : tgt_addr;
		end else begin
			raddr_a = tgt_addr;
			raddr_b = src_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= wr_pix;
		end
		rd_a <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr] <= wr_pix;
		end
		rd_b <= mem_b[raddr_b];
	end

	// centroid difference for the direction being started
	always_comb begin
		if (st_q == ST_MATCH) begin
			dxs = $signed(CW'(cxb_q)) - $signed(CW'(cxa_q));
			dys = $signed(CW'(cyb_q)) - $signed(CW'(cya_q));
		end else begin
			dxs = $signed(CW'(cxa_q)) - $signed(CW'(cxb_q));
			dys = $signed(CW'(cya_q)) - $signed(CW'(cyb_q));
		end
	end

	// match cost of the pixel pair now read
	assign src_px = dir_s1 ? rd_b : rd_a;
	assign tgt_px = dir_s1 ? rd_a : rd_b;
	always_comb begin
		if (!src_px.mask) begin
			cost = 8'd0;
		end else if (inr_s1 && tgt_px.eroded) begin
			cost = angle_dist(src_px.angle, tgt_px.angle);
		end else begin
			cost = MISS_COST;
		end
	end
	assign sum_now  = sum_q + DIFF_W'(cost);
	assign best_new = (sum_now < best_q) ? sum_now : best_q;

	// divider operands and one restoring step
	assign na_den = (na_q == '0) ? CNT_W'(1) : na_q;
	assign nb_den = (nb_q == '0) ? CNT_W'(1) : nb_q;
	always_comb begin
		unique case (job_q)
			JOB_CX_A: num_sel = NUM_W'(sxa_q);
			JOB_CY_A: num_sel = NUM_W'(sya_q);
			JOB_CX_B: num_sel = NUM_W'(sxb_q);
			JOB_CY_B: num_sel = NUM_W'(syb_q);
			JOB_Q_A:  num_sel = {da_q, 8'd0};
			default:  num_sel = {db_q, 8'd0};
		endcase
	end
	assign den   = (job_q == JOB_CX_A || job_q == JOB_CY_A || job_q == JOB_Q_A) ? na_den : nb_den;
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den});

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			issue_q <= 1'b0;
			dir_q   <= 1'b0;
			v_s1    <= 1'b0;
			job_q   <= JOB_CX_A;
			dcnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && st_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issue_q;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid && action == ACT_COMPUTE) begin
						st_q    <= ST_CSCAN;
						issue_q <= 1'b1;
						dir_q   <= 1'b0;
					end
				end
				ST_CSCAN: begin
					if (issue_q && last_pix) begin
						issue_q <= 1'b0;
					end
					if (v_s1 && end_s1) begin
						st_q   <= ST_DIV;
						job_q  <= JOB_CX_A;
						dcnt_q <= DCW'(NUM_W + 1);
					end
				end
				ST_DIV: begin
					if (dcnt_q != '0) begin
						dcnt_q <= dcnt_q - DCW'(1);
					end else if (job_q == JOB_CY_B) begin
						st_q    <= ST_MATCH;
						issue_q <= 1'b1;
						dir_q   <= 1'b0;
					end else if (job_q == JOB_Q_B) begin
						st_q <= ST_OUT;
					end else begin
						job_q  <= job_q + 3'd1;
						dcnt_q <= DCW'(NUM_W + 1);
					end
				end
				ST_MATCH: begin
					if (issue_q && last_all) begin
						if (!dir_q) begin
							dir_q <= 1'b1;
						end else begin
							issue_q <= 1'b0;
						end
					end
					if (v_s1 && end_s1 && dir_s1) begin
						st_q   <= ST_DIV;
						job_q  <= JOB_Q_A;
						dcnt_q <= DCW'(NUM_W + 1);
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// advance scan position and offsets
		if (st_q == ST_IDLE) begin
			x_q <= '0;
			y_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			ox_lo_q <= '0;
			ox_hi_q <= '0;
			oy_hi_q <= '0;
		end else if ((st_q == ST_DIV && dcnt_q == '0 && job_q == JOB_CY_B) ||
				(st_q == ST_MATCH && issue_q && last_all && !dir_q)) begin
			x_q <= '0;
			y_q <= '0;
			ox_q <= dxs - win;
			oy_q <= dys - win;
			ox_lo_q <= dxs - win;
			ox_hi_q <= dxs + win;
			oy_hi_q <= dys + win;
		end else if (issue_q) begin
			if (!x_last) begin
				x_q <= x_q + XW'(1);
			end else begin
				x_q <= '0;
				if (!y_last) begin
					y_q <= y_q + YW'(1);
				end else begin
					y_q <= '0;
					if (ox_q != ox_hi_q) begin
						ox_q <= ox_q + CW'(1);
					end else begin
						ox_q <= ox_lo_q;
						oy_q <= oy_q + CW'(1);
					end
				end
			end
		end

		// stage one flags
		x_s1    <= x_q;
		y_s1    <= y_q;
		dir_s1  <= dir_q;
		inr_s1  <= inr;
		last_s1 <= last_pix;
		end_s1  <= (st_q == ST_CSCAN) ? last_pix : last_all;
		in_a_s1 <= (32'(x_q) < 32'(wa)) && (32'(y_q) < 32'(ha));
		in_b_s1 <= (32'(x_q) < 32'(wb)) && (32'(y_q) < 32'(hb));

		// centroid sums
		if (st_q == ST_IDLE) begin
			na_q <= '0;
			nb_q <= '0;
			sxa_q <= '0;
			sya_q <= '0;
			sxb_q <= '0;
			syb_q <= '0;
		end else if (st_q == ST_CSCAN && v_s1) begin
			if (in_a_s1 && rd_a.mask) begin
				na_q  <= na_q + CNT_W'(1);
				sxa_q <= sxa_q + SX_W'(x_s1);
				sya_q <= sya_q + SY_W'(y_s1);
			end
			if (in_b_s1 && rd_b.mask) begin
				nb_q  <= nb_q + CNT_W'(1);
				sxb_q <= sxb_q + SX_W'(x_s1);
				syb_q <= syb_q + SY_W'(y_s1);
			end
		end

		// offset sums and running minimum
		if (st_q != ST_MATCH) begin
			sum_q  <= '0;
			best_q <= '1;
		end else if (v_s1) begin
			sum_q <= last_s1 ? '0 : sum_now;
			if (last_s1) begin
				if (end_s1) begin
					best_q <= '1;
					if (dir_s1) begin
						db_q <= best_new;
					end else begin
						da_q <= best_new;
					end
				end else begin
					best_q <= best_new;
				end
			end
		end

		// divider: load, step, drop result
		if (st_q == ST_DIV) begin
			if (dcnt_q == DCW'(NUM_W + 1)) begin
				quo_q <= num_sel;
				rem_q <= '0;
			end else if (dcnt_q != '0) begin
				quo_q <= {quo_q[NUM_W-2:0], ge};
				rem_q <= ge ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
			end
		end
		if (st_q == ST_DIV && dcnt_q == DCW'(1)) begin
			unique case (job_q)
				JOB_CX_A: cxa_q <= (na_q == '0) ? XW'(wa >> 1) : XW'({quo_q[NUM_W-2:0], ge});
				JOB_CY_A: cya_q <= (na_q == '0) ? YW'(ha >> 1) : YW'({quo_q[NUM_W-2:0], ge});
				JOB_CX_B: cxb_q <= (nb_q == '0) ? XW'(wb >> 1) : XW'({quo_q[NUM_W-2:0], ge});
				JOB_CY_B: cyb_q <= (nb_q == '0) ? YW'(hb >> 1) : YW'({quo_q[NUM_W-2:0], ge});
				JOB_Q_A:  qa_q  <= 16'({quo_q[NUM_W-2:0], ge});
				default:  qb_q  <= 16'({quo_q[NUM_W-2:0], ge});
			endcase
		end

		// result register
		if (st_q == ST_OUT && (!out_valid_q || out_ready)) begin
			dist_q <= (qa_q > qb_q) ? qa_q : qb_q;
			oda_q  <= 20'(da_q);
			odb_q  <= 20'(db_q);
			ona_q  <= 13'(na_den);
			onb_q  <= 13'(nb_den);
		end
	end

	assign out_valid   = out_valid_q;
	assign distance_q8 = dist_q;
	assign diff_a_to_b = oda_q;
	assign diff_b_to_a = odb_q;
	assign count_a     = ona_q;
	assign count_b     = onb_q;

	a_idle_no_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !v_s1)
		else $error("read pipeline active while idle");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(st_q) == ST_OUT))
		else $error("result raised outside output step");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (dcnt_q <= DCW'(NUM_W + 1)))
		else $error("divider count out of range");
	a_out_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |-> !issue_q)
		else $error("scan still issuing at result");

endmodule

/* verif/tb.sv */
module tb;
	import gatd_pkg::*;

	localparam int MAXW       = 64;
	localparam int MAXH       = 64;
	localparam int MAXWIN     = 15;
	localparam int DEPTH      = MAXW * MAXH;
	localparam int SETTLE     = 12;
	localparam int HOLD_LEN   = 15000;
	localparam int CALM_TAIL  = 100;
	localparam int CYCLE_CAP  = 4000000;

	localparam logic IMG_A = 1'b0;
	localparam logic IMG_B = 1'b1;

	typedef struct {
		bit         is_cfg;
		logic [2:0] idx;
		logic [6:0] data;
		logic       act;
		logic       img;
		logic [5:0] x;
		logic [5:0] y;
		logic [7:0] ang;
		logic       m;
		logic       e;
	} op_t;

	typedef struct {
		logic [15:0] q8;
		logic [19:0] dab;
		logic [19:0] dba;
		logic [12:0] na;
		logic [12:0] nb;
	} dist_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic        which_image = 1'b0;
	logic [5:0]  pix_x = '0;
	logic [5:0]  pix_y = '0;
	logic [7:0]  pix_angle = '0;
	logic        pix_in_mask = 1'b0;
	logic        pix_in_eroded = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] distance_q8;
	logic [19:0] diff_a_to_b;
	logic [19:0] diff_b_to_a;
	logic [12:0] count_a;
	logic [12:0] count_b;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	gradient_angle_template_distance u_dut (.*);

	// toggle clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	op_t   op_q[$];
	dist_t dist_q[$];
	int    errors = 0;
	int    results_seen = 0;

	// predictor state
	logic [7:0] ang_st[2][DEPTH];
	bit         msk_st[2][DEPTH];
	bit         ero_st[2][DEPTH];
	logic [6:0] p_dim[2][2];
	logic [3:0] p_win;

	// stimulus-side view of sizes and written pixels
	bit gen_wr[2][DEPTH];
	int gen_dim[2][2];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic int clampd(input logic [6:0] v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic int angdiff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = a - b;
		return (d > 8'd128) ? 256 - int'(d) : int'(d);
	endfunction

	// minimum cost of matching image s onto image t
	function automatic int min_cost(input int s, input int cx[2], input int cy[2],
			input int w[2], input int h[2], input int win);
		int t, best, sum, ox, oy, x, y, tx, ty, si;
		t = 1 - s;
		best = 32'h7fffffff;
		for (oy = cy[s] - cy[t] - win; oy <= cy[s] - cy[t] + win; oy++)
			for (ox = cx[s] - cx[t] - win; ox <= cx[s] - cx[t] + win; ox++) begin
				sum = 0;
				for (y = 0; y < h[s]; y++)
					for (x = 0; x < w[s]; x++) begin
						si = y * MAXW + x;
						tx = x - ox;
						ty = y - oy;
						if (!msk_st[s][si]) continue;
						if (tx >= 0 && tx < w[t] && ty >= 0 && ty < h[t] &&
								ero_st[t][ty * MAXW + tx])
							sum += angdiff(ang_st[s][si], ang_st[t][ty * MAXW + tx]);
						else
							sum += 128;
					end
				if (sum < best) best = sum;
			end
		return best;
	endfunction

	function automatic dist_t predict_distance();
		int w[2], h[2], cx[2], cy[2], n[2], sx, sy, i, x, y, win, da, db;
		longint qa, qb;
		dist_t r;
		for (i = 0; i < 2; i++) begin
			w[i] = clampd(p_dim[i][0], MAXW);
			h[i] = clampd(p_dim[i][1], MAXH);
			n[i] = 0; sx = 0; sy = 0;
			for (y = 0; y < h[i]; y++)
				for (x = 0; x < w[i]; x++)
					if (msk_st[i][y * MAXW + x]) begin
						n[i]++; sx += x; sy += y;
					end
			cx[i] = n[i] != 0 ? sx / n[i] : w[i] / 2;
			cy[i] = n[i] != 0 ? sy / n[i] : h[i] / 2;
			if (n[i] == 0) n[i] = 1;
		end
		win = p_win > MAXWIN ? MAXWIN : int'(p_win);
		da = min_cost(0, cx, cy, w, h, win);
		db = min_cost(1, cx, cy, w, h, win);
		qa = (longint'(da) << 8) / n[0];
		qb = (longint'(db) << 8) / n[1];
		r.q8  = 16'(qa > qb ? qa : qb);
		r.dab = 20'(da);
		r.dba = 20'(db);
		r.na  = 13'(n[0]);
		r.nb  = 13'(n[1]);
		return r;
	endfunction

	// apply one accepted transfer to the predictor
	task automatic absorb(input op_t o);
		int i;
		if (o.is_cfg) begin
			case (o.idx)
				REG_WIDTH_A:       p_dim[0][0] = o.data;
				REG_HEIGHT_A:      p_dim[0][1] = o.data;
				REG_WIDTH_B:       p_dim[1][0] = o.data;
				REG_HEIGHT_B:      p_dim[1][1] = o.data;
				REG_SEARCH_WINDOW: p_win = o.data[3:0];
				default: ;
			endcase
		end else if (o.act == ACT_LOAD) begin
			i = int'(o.y) * MAXW + int'(o.x);
			ang_st[o.img][i] = o.ang;
			msk_st[o.img][i] = o.m;
			ero_st[o.img][i] = o.e;
		end else begin
			dist_q.push_back(predict_distance());
		end
	endtask

	// stimulus builders
	task automatic add_cfg(input logic [2:0] idx, input logic [6:0] val);
		op_t o;
		o = '{default: '0};
		o.is_cfg = 1'b1; o.idx = idx; o.data = val;
		op_q.push_back(o);
		case (idx)
			REG_WIDTH_A:  gen_dim[0][0] = clampd(val, MAXW);
			REG_HEIGHT_A: gen_dim[0][1] = clampd(val, MAXH);
			REG_WIDTH_B:  gen_dim[1][0] = clampd(val, MAXW);
			REG_HEIGHT_B: gen_dim[1][1] = clampd(val, MAXH);
			default: ;
		endcase
	endtask

	task automatic add_sizes(input int wa, input int ha, input int wb, input int hb,
			input int win);
		add_cfg(REG_WIDTH_A, 7'(wa));
		add_cfg(REG_HEIGHT_A, 7'(ha));
		add_cfg(REG_WIDTH_B, 7'(wb));
		add_cfg(REG_HEIGHT_B, 7'(hb));
		add_cfg(REG_SEARCH_WINDOW, 7'(win));
	endtask

	task automatic add_pix(input logic img, input int x, input int y, input logic [7:0] ang,
			input logic m, input logic e);
		op_t o;
		o = '{default: '0};
		o.act = ACT_LOAD; o.img = img; o.x = 6'(x); o.y = 6'(y);
		o.ang = ang; o.m = m; o.e = e;
		op_q.push_back(o);
		gen_wr[img][y * MAXW + x] = 1'b1;
	endtask

	task automatic add_rand_pix(input logic img, input int x, input int y);
		logic m;
		m = $urandom_range(0, 9) < 6;
		add_pix(img, x, y, 8'($urandom), m, m ? ($urandom_range(0, 3) != 0) : 1'($urandom));
	endtask

	// load whatever a compute would read unwritten, then start it
	task automatic add_compute();
		op_t o;
		int i, x, y;
		for (i = 0; i < 2; i++)
			for (y = 0; y < gen_dim[i][1]; y++)
				for (x = 0; x < gen_dim[i][0]; x++)
					if (!gen_wr[i][y * MAXW + x]) add_rand_pix(1'(i), x, y);
		o = '{default: '0};
		o.act = ACT_COMPUTE;
		o.img = 1'($urandom);
		o.x = 6'($urandom); o.y = 6'($urandom); o.ang = 8'($urandom);
		o.m = 1'($urandom); o.e = 1'($urandom);
		op_q.push_back(o);
	endtask

	// driver: input and configuration channels
	op_t in_cur, cfg_cur, head;
	int  gap = 0;
	int  settle = 0;
	bit  nv_in, nv_cfg;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			settle = 0;
		end else begin
			nv_in = in_valid;
			nv_cfg = cfg_valid;
			settle++;
			if (out_valid && out_ready) settle = 0;
			if (in_valid && in_ready) begin
				absorb(in_cur);
				nv_in = 1'b0;
				settle = 0;
			end
			if (cfg_valid && cfg_ready) begin
				absorb(cfg_cur);
				nv_cfg = 1'b0;
			end
			// pick the next transfer
			if (!nv_in && !nv_cfg && op_q.size() > 0) begin
				if (gap > 0) begin
					gap--;
				end else begin
					head = op_q[0];
					if (head.is_cfg) begin
						if (dist_q.size() == 0 && settle >= SETTLE) begin
							cfg_cur = head;
							cfg_index <= head.idx;
							cfg_data <= head.data;
							nv_cfg = 1'b1;
							void'(op_q.pop_front());
						end
					end else begin
						in_cur = head;
						action <= head.act;
						which_image <= head.img;
						pix_x <= head.x;
						pix_y <= head.y;
						pix_angle <= head.ang;
						pix_in_mask <= head.m;
						pix_in_eroded <= head.e;
						nv_in = 1'b1;
						void'(op_q.pop_front());
					end
					if (op_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
						gap = $urandom_range(1, 17);
				end
			end
			in_valid <= nv_in;
			cfg_valid <= nv_cfg;
		end
	end

	// receiver: random stalls and one long hold-off
	int  rgap = 0;
	int  hold_cnt = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (!hold_done && out_valid && results_seen >= 6) begin
			hold_done = 1'b1;
			hold_cnt = HOLD_LEN;
			out_ready <= 1'b0;
		end else if (rgap > 0) begin
			rgap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (op_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
				rgap = $urandom_range(1, 17);
		end
	end

	// monitor: compare each result transfer with the oldest prediction
	dist_t want;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (dist_q.size() == 0) begin
				report("unexpected result", distance_q8, 0);
			end else begin
				want = dist_q.pop_front();
				if (distance_q8 !== want.q8)  report("distance_q8", distance_q8, want.q8);
				if (diff_a_to_b !== want.dab) report("diff_a_to_b", diff_a_to_b, want.dab);
				if (diff_b_to_a !== want.dba) report("diff_b_to_a", diff_b_to_a, want.dba);
				if (count_a !== want.na)      report("count_a", count_a, want.na);
				if (count_b !== want.nb)      report("count_b", count_b, want.nb);
			end
		end
	end

	// watchdog
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("gradient_angle_template_distance verification failed");
			$finish;
		end
	end

	initial begin
		int ph, k, n, y, sz;
		for (k = 0; k < 2; k++) begin
			p_dim[k][0] = DIM_RESET; p_dim[k][1] = DIM_RESET;
			gen_dim[k][0] = 64; gen_dim[k][1] = 64;
		end
		p_win = WIN_RESET;

		// directed: angle extremes and wrap, 2x2 images, no search
		add_sizes(2, 2, 2, 2, 0);
		add_pix(IMG_A, 0, 0, 8'd0, 1'b1, 1'b1);
		add_pix(IMG_A, 1, 0, 8'd255, 1'b1, 1'b1);
		add_pix(IMG_A, 0, 1, 8'd128, 1'b1, 1'b0);
		add_pix(IMG_A, 1, 1, 8'd1, 1'b1, 1'b1);
		add_pix(IMG_B, 0, 0, 8'd128, 1'b1, 1'b1);
		add_pix(IMG_B, 1, 0, 8'd0, 1'b1, 1'b1);
		add_pix(IMG_B, 0, 1, 8'd255, 1'b1, 1'b1);
		add_pix(IMG_B, 1, 1, 8'd127, 1'b0, 1'b1);
		add_compute();
		// empty mask on A
		for (k = 0; k < 4; k++) add_pix(IMG_A, k % 2, k / 2, 8'd255, 1'b0, 1'b0);
		add_compute();
		// ignored indexes, zero width, oversize height
		add_cfg(3'd5, 7'h7f);
		add_cfg(3'd6, 7'h55);
		add_cfg(3'd7, 7'h2a);
		add_cfg(REG_WIDTH_A, 7'd0);
		add_cfg(REG_HEIGHT_B, 7'd127);
		add_cfg(REG_SEARCH_WINDOW, 7'd1);
		add_compute();
		// far corners, then full-width and full-height strips
		add_pix(IMG_A, 63, 63, 8'd200, 1'b1, 1'b1);
		add_pix(IMG_B, 63, 63, 8'd72, 1'b1, 1'b1);
		add_sizes(64, 1, 64, 1, 2);
		add_compute();
		add_sizes(1, 64, 1, 64, 0);
		add_compute();
		add_sizes(1, 1, 1, 1, 15);
		add_compute();
		// loads and computes with no configuration between, so a held result
		// backs up the input
		for (k = 0; k < 4; k++) begin
			add_pix(IMG_A, 0, 0, 8'($urandom), 1'b1, 1'b1);
			add_compute();
		end

		// random phases
		for (ph = 0; ph < 38; ph++) begin
			if (ph < 3 || ph > 7 || $urandom_range(0, 1) == 0) begin
				n = $urandom_range(0, 9);
				if (n == 0) add_sizes($urandom_range(1, 3), $urandom_range(1, 3),
						$urandom_range(1, 3), $urandom_range(1, 3), 15);
				else begin
					sz = n < 3 ? 8 : 5;
					add_sizes($urandom_range(1, sz), $urandom_range(1, sz),
						$urandom_range(1, sz), $urandom_range(1, sz), $urandom_range(0, 3));
				end
			end
			n = $urandom_range(4, 20);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0) add_rand_pix(1'($urandom), $urandom_range(0, 63),
						$urandom_range(0, 63));
				else begin
					y = $urandom_range(0, 1);
					add_rand_pix(1'(y), $urandom_range(0, gen_dim[y][0] - 1),
						$urandom_range(0, gen_dim[y][1] - 1));
				end
			end
			add_compute();
		end

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (op_q.size() == 0 && !in_valid && !cfg_valid);
		wait (dist_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("gradient_angle_template_distance verification clean");
		else
			$display("gradient_angle_template_distance verification failed");
		$finish;
	end

endmodule

/* gradient_angle_template_distance.f */
hdl/gatd_pkg.sv
hdl/gradient_angle_template_distance.sv
verif/tb.sv
